[design/trpt_pkg.sv]
package trpt_pkg;

	// request opcodes
	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_REPLY = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_FORWARD = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_REPLY   = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;
	localparam int CFG_DATA_W = 31;

	localparam logic [30:0] TIMEOUT_RESET   = 31'd2000000;
	localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
	localparam logic [7:0]  COUNT_MAX       = 8'd255;

	// results per sweep tick
	localparam int MAX_OUT = 16;
	localparam int HITS_W  = $clog2(MAX_OUT + 1);

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] txid;
		logic [31:0] client_ip;
		logic [15:0] client_port;
		logic [31:0] now_us;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [15:0] client_txid_out;
		logic [31:0] client_ip_out;
		logic [15:0] client_port_out;
		logic        upstream_sel;
		logic        failed_over;
		logic        last;
	} rsp_item_t;

	// one table entry in the slot memory
	typedef struct packed {
		logic [15:0] orig_txid;
		logic [31:0] client_ip;
		logic [15:0] client_port;
		logic [31:0] sent_time;
	} slot_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPLY,
		ST_SWEEP,
		ST_FLUSH
	} state_t;

endpackage

[design/txid_remap_pending_table.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_data   (req_item_t)
// rsp     | out       | rsp_valid, rsp_stall | rsp_data   (rsp_item_t)
// cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// a query passes through FLUSH, a reply through REPLY and FLUSH, a tick through SWEEP and FLUSH; the
// sweep walks the slot memory one entry a cycle, unless held, through its single read port
// one item is worked at a time; req_stall is high until the item is finished
// a sweep halts on an expiry while a result waits and the output register is held
// reset clears the valid bits, counters and handshakes; slot payloads are
// read only for valid slots, so the memory needs no clearing pass
module txid_remap_pending_table
	import trpt_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_item_t            req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_item_t            rsp_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

	state_t state_q, state_d;

	logic [SLOTS-1:0]  valid_q;
	slot_word_t        mem [SLOTS];
	slot_word_t        rdata_s1;
	logic [IdxW-1:0]   idx_s1;
	logic [IdxW-1:0]   rd_addr;

	logic [31:0]       now_q;
	logic [30:0]       timeout_q;
	logic [7:0]        thresh_q;
	logic [7:0]        tcount_q, tcount_d;
	logic              upsel_q, upsel_d;
	logic [HITS_W-1:0] hits_q;

	logic              pend_valid_q;
	rsp_item_t         pend_q, pend_d;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	// control from the sequencer
	logic              pend_load, push, push_last;
	logic              wr_en, set_v, clr_v;
	logic              hits_inc, hits_clr, now_load;

	logic              free_found;
	logic [IdxW-1:0]   free_idx;
	logic              rsp_free;
	logic [31:0]       age;
	logic              expired;
	logic              at_end;
	logic [7:0]        cnt_inc;
	logic              fo_hit;
	logic [IdxW-1:0]   req_idx;
	logic              reply_ok;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IdxW'(i);
			end
		end
	end

	// expiry check and failover count for the entry under the sweep
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign age      = now_q - rdata_s1.sent_time;
	assign expired  = valid_q[idx_s1] && !age[31] && (age[30:0] >= timeout_q);
	assign at_end   = (idx_s1 == LastIdx);
	assign cnt_inc  = (tcount_q == COUNT_MAX) ? COUNT_MAX : tcount_q + 8'd1;
	assign fo_hit   = (cnt_inc >= thresh_q);
	assign req_idx  = req_data.txid[IdxW-1:0];
	assign reply_ok = (req_data.txid < 16'(SLOTS)) && valid_q[req_idx];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rd_addr   = idx_s1;
		pend_load = 1'b0;
		pend_d    = '0;
		push      = 1'b0;
		push_last = 1'b0;
		wr_en     = 1'b0;
		set_v     = 1'b0;
		clr_v     = 1'b0;
		hits_inc  = 1'b0;
		hits_clr  = 1'b0;
		now_load  = 1'b0;
		tcount_d  = tcount_q;
		upsel_d   = upsel_q;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				rd_addr   = (req_data.op == OP_REPLY) ? req_idx : '0;
				if (req_valid) begin
					case (req_data.op)
						OP_QUERY: begin
							pend_load              = 1'b1;
							pend_d.client_txid_out = req_data.txid;
							pend_d.client_ip_out   = req_data.client_ip;
							pend_d.client_port_out = req_data.client_port;
							pend_d.upstream_sel    = upsel_q;
							pend_d.last            = 1'b1;
							if (free_found) begin
								wr_en       = 1'b1;
								set_v       = 1'b1;
								pend_d.kind = KIND_FORWARD;
								pend_d.slot = 4'(free_idx);
							end else begin
								pend_d.kind = KIND_FULL;
							end
							state_d = ST_FLUSH;
						end
						OP_REPLY: begin
							if (reply_ok) begin
								state_d = ST_REPLY;
							end
						end
						OP_TICK: begin
							hits_clr = 1'b1;
							now_load = 1'b1;
							state_d  = ST_SWEEP;
						end
						default: begin
						end
					endcase
				end
			end
			ST_REPLY: begin
				pend_load              = 1'b1;
				pend_d.kind            = KIND_REPLY;
				pend_d.slot            = 4'(idx_s1);
				pend_d.client_txid_out = rdata_s1.orig_txid;
				pend_d.client_ip_out   = rdata_s1.client_ip;
				pend_d.client_port_out = rdata_s1.client_port;
				pend_d.upstream_sel    = upsel_q;
				pend_d.last            = 1'b1;
				clr_v                  = 1'b1;
				tcount_d               = '0;
				state_d                = ST_FLUSH;
			end
			ST_SWEEP: begin
				rd_addr = at_end ? '0 : idx_s1 + 1'b1;
				if (expired) begin
					if (pend_valid_q && !rsp_free) begin
						// hold the walk on this entry
						rd_addr = idx_s1;
					end else begin
						push                   = pend_valid_q;
						pend_load              = 1'b1;
						pend_d.kind            = KIND_TIMEOUT;
						pend_d.slot            = 4'(idx_s1);
						pend_d.client_txid_out = rdata_s1.orig_txid;
						pend_d.client_ip_out   = rdata_s1.client_ip;
						pend_d.client_port_out = rdata_s1.client_port;
						pend_d.failed_over     = fo_hit;
						pend_d.upstream_sel    = upsel_q ^ fo_hit;
						clr_v                  = 1'b1;
						hits_inc               = 1'b1;
						upsel_d                = upsel_q ^ fo_hit;
						tcount_d               = fo_hit ? '0 : cnt_inc;
						if (at_end || (hits_q == HITS_W'(MAX_OUT - 1))) begin
							state_d = ST_FLUSH;
						end
					end
				end else if (at_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (rsp_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[free_idx] <= '{orig_txid:   req_data.txid,
			                   client_ip:   req_data.client_ip,
			                   client_port: req_data.client_port,
			                   sent_time:   req_data.now_us};
		end
		rdata_s1 <= mem[rd_addr];
	end

	// valid bits and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_s1       <= '0;
			tcount_q     <= '0;
			upsel_q      <= 1'b0;
			hits_q       <= '0;
			pend_valid_q <= 1'b0;
			timeout_q    <= TIMEOUT_RESET;
			thresh_q     <= THRESHOLD_RESET;
		end else begin
			idx_s1   <= rd_addr;
			tcount_q <= tcount_d;
			upsel_q  <= upsel_d;
			if (set_v) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (clr_v) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (hits_clr) begin
				hits_q <= '0;
			end else if (hits_inc) begin
				hits_q <= hits_q + 1'b1;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (push) begin
				pend_valid_q <= 1'b0;
			end
			// configuration writes
			if (cfg_we && (cfg_index == REG_TIMEOUT)) begin
				timeout_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == REG_THRESHOLD)) begin
				thresh_q <= cfg_data[7:0];
			end
		end
	end

	// pending result and sweep time
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (now_load) begin
			now_q <= req_data.now_us;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// last flag sits in the low bit of the result
	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= {pend_q[$bits(rsp_item_t)-1:1], push_last};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// no result is left behind when the sequencer is idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left in idle");

	// a transfer into the output register never overwrites a held result
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!rsp_valid_q || !rsp_stall))
		else $error("output register overwritten");

	// the sweep stops at the per-tick result limit
	a_hits_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (hits_q < HITS_W'(MAX_OUT)))
		else $error("sweep past result limit");

	// a reply is only worked on a slot that is still valid
	a_reply_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLY) |-> valid_q[idx_s1])
		else $error("reply on free slot");

endmodule

[tb/txid_remap_pending_table_tb.sv]
module txid_remap_pending_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trpt_pkg::*;

	localparam int N_SLOTS = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 2 * N_SLOTS + 8;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// expected-result tracking for the pending-request table
	class pending_table_scoreboard;
		logic [30:0] tmo_us;
		logic [7:0] fail_thr;
		bit slot_busy [N_SLOTS];
		logic [15:0] saved_txid [N_SLOTS];
		logic [31:0] slot_ip [N_SLOTS];
		logic [15:0] slot_port [N_SLOTS];
		logic [31:0] slot_sent [N_SLOTS];
		logic [7:0] miss_count;
		logic upstream;
		rsp_item_t expected_rsp_q [$];
		int errors;
		int n_req;
		int n_rsp;
		int n_kind [4];
		int n_failover;

		function new();
			tmo_us = TIMEOUT_RESET;
			fail_thr = THRESHOLD_RESET;
			miss_count = '0;
			upstream = 1'b0;
			foreach (slot_busy[i]) slot_busy[i] = 1'b0;
			errors = 0;
			n_req = 0;
			n_rsp = 0;
			n_failover = 0;
			foreach (n_kind[i]) n_kind[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_TIMEOUT) tmo_us = value;
			else if (idx == REG_THRESHOLD) fail_thr = value[7:0];
		endfunction

		function rsp_item_t make_rsp(logic [1:0] kind, int idx, logic [15:0] txid,
				logic [31:0] ip, logic [15:0] port, logic fo);
			rsp_item_t r;
			r.kind = kind;
			r.slot = 4'(idx);
			r.client_txid_out = txid;
			r.client_ip_out = ip;
			r.client_port_out = port;
			r.upstream_sel = upstream;
			r.failed_over = fo;
			r.last = 1'b0;
			return r;
		endfunction

		// update the table for one accepted request and queue its results
		function void note_request(req_item_t q);
			rsp_item_t batch [$];
			int free_idx;
			logic [31:0] age;
			logic fo;
			free_idx = -1;
			n_req++;
			case (q.op)
				OP_QUERY: begin
					for (int i = 0; i < N_SLOTS; i++)
						if (!slot_busy[i] && free_idx < 0) free_idx = i;
					if (free_idx < 0) begin
						batch.push_back(make_rsp(KIND_FULL, 0, q.txid, q.client_ip,
							q.client_port, 1'b0));
					end else begin
						slot_busy[free_idx] = 1'b1;
						saved_txid[free_idx] = q.txid;
						slot_ip[free_idx] = q.client_ip;
						slot_port[free_idx] = q.client_port;
						slot_sent[free_idx] = q.now_us;
						batch.push_back(make_rsp(KIND_FORWARD, free_idx, q.txid, q.client_ip,
							q.client_port, 1'b0));
					end
				end
				OP_REPLY: begin
					if (q.txid < N_SLOTS && slot_busy[q.txid]) begin
						batch.push_back(make_rsp(KIND_REPLY, int'(q.txid), saved_txid[q.txid],
							slot_ip[q.txid], slot_port[q.txid], 1'b0));
						slot_busy[q.txid] = 1'b0;
						miss_count = '0;
					end
				end
				OP_TICK: begin
					for (int i = 0; i < N_SLOTS && batch.size() < MAX_OUT; i++) begin
						if (!slot_busy[i]) continue;
						// wrap-safe age, negative never expires
						age = q.now_us - slot_sent[i];
						if (age[31] || age < {1'b0, tmo_us}) continue;
						slot_busy[i] = 1'b0;
						if (miss_count != COUNT_MAX) miss_count++;
						fo = 1'b0;
						if (miss_count >= fail_thr) begin
							upstream = ~upstream;
							miss_count = '0;
							fo = 1'b1;
						end
						batch.push_back(make_rsp(KIND_TIMEOUT, i, saved_txid[i], slot_ip[i],
							slot_port[i], fo));
					end
				end
				default: ;
			endcase
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) expected_rsp_q.push_back(batch[i]);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (expected_rsp_q.size() == 0) begin
				$error("result with nothing expected: %p", got);
				errors++;
				return;
			end
			want = expected_rsp_q.pop_front();
			check_field("kind", 32'(want.kind), 32'(got.kind));
			check_field("slot", 32'(want.slot), 32'(got.slot));
			check_field("client_txid_out", 32'(want.client_txid_out),
				32'(got.client_txid_out));
			check_field("client_ip_out", want.client_ip_out, got.client_ip_out);
			check_field("client_port_out", 32'(want.client_port_out),
				32'(got.client_port_out));
			check_field("upstream_sel", 32'(want.upstream_sel), 32'(got.upstream_sel));
			check_field("failed_over", 32'(want.failed_over), 32'(got.failed_over));
			check_field("last", 32'(want.last), 32'(got.last));
			n_rsp++;
			n_kind[want.kind]++;
			if (want.failed_over) n_failover++;
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	req_item_t req_data = '0;
	logic req_stall;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int n_settings = 0;
	logic [31:0] cur_us;

	pending_table_scoreboard board = new();

	txid_remap_pending_table #(
		.SLOTS(N_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_item_t mk_req(logic [1:0] op, logic [15:0] txid, logic [31:0] ip,
			logic [15:0] port, logic [31:0] now_us);
		req_item_t r;
		r.op = op;
		r.txid = txid;
		r.client_ip = ip;
		r.client_port = port;
		r.now_us = now_us;
		return r;
	endfunction

	// offer one request and hold it until the transfer
	task automatic send_req(input req_item_t item);
		int gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (req_stall);
		board.note_request(item);
	endtask

	// stop offering, wait for every expected result, then let a sweep finish
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (board.expected_rsp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic settle_and_configure(input logic [30:0] tmo, input logic [7:0] thr);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_data <= {23'd0, thr};
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(REG_TIMEOUT, tmo);
		board.write_reg(REG_THRESHOLD, {23'd0, thr});
		n_settings++;
	endtask

	// mostly queries, replies to live slots and ticks, some near expiry, some bad replies and noise
	task automatic run_random_phase(input int n_items);
		req_item_t item;
		int counted;
		int pick;
		int k;
		int busy_list [$];
		logic [31:0] step_max;
		counted = 0;
		while (counted < n_items) begin
			item = mk_req(OP_QUERY, 16'($urandom), $urandom, 16'($urandom), cur_us);
			busy_list.delete();
			foreach (board.slot_busy[i]) if (board.slot_busy[i]) busy_list.push_back(i);
			pick = $urandom_range(99);
			if (pick < 40) begin
				item.op = OP_QUERY;
			end else if (pick < 68) begin
				item.op = OP_REPLY;
				if (busy_list.size() > 0 && $urandom_range(99) < 80)
					item.txid = 16'(busy_list[$urandom_range(busy_list.size() - 1)]);
				else if ($urandom_range(1) == 1)
					item.txid = 16'($urandom_range(N_SLOTS - 1));
			end else if (pick < 95) begin
				item.op = OP_TICK;
				// land right on, before or after some slot's expiry
				if (busy_list.size() > 0 && $urandom_range(99) < 30) begin
					k = busy_list[$urandom_range(busy_list.size() - 1)];
					item.now_us = board.slot_sent[k] + {1'b0, board.tmo_us}
						+ $urandom_range(2) - 32'd1;
				end
			end else begin
				item.op = OP_UNUSED;
			end
			send_req(item);
			if (item.op != OP_UNUSED) counted++;
			// advance the microsecond clock on the scale of the timeout
			step_max = (board.tmo_us > 31'd400000) ? 32'd100000 : {1'b0, board.tmo_us} / 4 + 1;
			cur_us += $urandom_range(step_max);
			if ($urandom_range(99) < 2) cur_us += $urandom;
		end
	endtask

	// result side: check transfers, stall at random or for a long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
			else quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// stimulus
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		cur_us = $urandom;

		settle_and_configure(31'd100, 8'd2);
		// extreme field values, slot 0 and slot 1
		send_req(mk_req(OP_QUERY, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000));
		send_req(mk_req(OP_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
		// good reply, then the same slot again once freed
		send_req(mk_req(OP_REPLY, 16'd0, $urandom, 16'($urandom), $urandom));
		send_req(mk_req(OP_REPLY, 16'd0, $urandom, 16'($urandom), $urandom));
		// reply ids past the table
		send_req(mk_req(OP_REPLY, 16'hFFFF, $urandom, 16'($urandom), $urandom));
		send_req(mk_req(OP_REPLY, 16'(N_SLOTS), $urandom, 16'($urandom), $urandom));
		// undefined opcode is dropped
		send_req(mk_req(OP_UNUSED, 16'($urandom), $urandom, 16'($urandom), $urandom));
		// negative age, one short of timeout, then exactly timeout across the wrap
		send_req(mk_req(OP_TICK, 16'($urandom), $urandom, 16'($urandom), 32'h7FFF_FFFF));
		send_req(mk_req(OP_TICK, 16'($urandom), $urandom, 16'($urandom), 32'd98));
		send_req(mk_req(OP_TICK, 16'($urandom), $urandom, 16'($urandom), 32'd99));
		// fill every slot, overflow once, then expire the whole table in one tick
		for (int i = 0; i < N_SLOTS; i++)
			send_req(mk_req(OP_QUERY, 16'($urandom), $urandom, 16'($urandom), 32'd1000 + i));
		send_req(mk_req(OP_QUERY, 16'($urandom), $urandom, 16'($urandom), 32'd2000));
		send_req(mk_req(OP_TICK, 16'($urandom), $urandom, 16'($urandom),
			32'd1000 + N_SLOTS - 1 + 100));

		// no idling, with a long hold-off on the result side
		settle_and_configure(31'd1, 8'd1);
		hold_request = HOLD_CYCLES;
		run_random_phase(PHASE_ITEMS);

		gap_pct = 77;
		settle_and_configure(31'h7FFF_FFFF, 8'd255);
		run_random_phase(PHASE_ITEMS);

		gap_pct = 0;
		stall_pct = 77;
		settle_and_configure(31'($urandom_range(5000, 200)), 8'($urandom_range(4, 1)));
		run_random_phase(PHASE_ITEMS);

		gap_pct = 37;
		stall_pct = 37;
		settle_and_configure(31'($urandom_range(100000, 1)), 8'($urandom_range(8, 2)));
		run_random_phase(PHASE_ITEMS);

		wait_idle();
		$display("covered %0d requests, %0d results: %0d forwarded, %0d table full, %0d replies,",
			board.n_req, board.n_rsp, board.n_kind[KIND_FORWARD], board.n_kind[KIND_FULL],
			board.n_kind[KIND_REPLY]);
		$display("%0d timeouts, %0d failovers, over %0d register settings and four pacing mixes",
			board.n_kind[KIND_TIMEOUT], board.n_failover, n_settings);
		if (board.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
